// ===== design/coapd_pkg.sv =====
// ----------------------------------------------------------------------------
// coapd_pkg
// shared types, codes and the option class lookup of the option decoder
// ----------------------------------------------------------------------------
package coapd_pkg;

   // parser position inside one option
   typedef enum logic [2:0] {
      PH_HEADER,
      PH_DELTA_HI,
      PH_DELTA_LO,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_VALUE,
      PH_ERROR
   } phase_type;

   // value formats
   localparam logic [1:0] FMT_EMPTY  = 2'd0;
   localparam logic [1:0] FMT_OPAQUE = 2'd1;
   localparam logic [1:0] FMT_UINT   = 2'd2;
   localparam logic [1:0] FMT_STRING = 2'd3;

   // result beat kinds
   localparam logic [1:0] EV_VALUE    = 2'd0;
   localparam logic [1:0] EV_COMPLETE = 2'd1;
   localparam logic [1:0] EV_ERROR    = 2'd2;

   // error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_DELTA15  = 2'd1;
   localparam logic [1:0] ERR_LENGTH15 = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW = 2'd3;

   // nibble codes and extension offsets
   localparam logic [3:0]  NIB_MAX_SHORT = 4'd12;
   localparam logic [3:0]  NIB_EXT_ONE   = 4'd13;
   localparam logic [3:0]  NIB_RESERVED  = 4'd15;
   localparam logic [16:0] EXT_ONE       = 17'd13;
   localparam logic [16:0] EXT_TWO       = 17'd269;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [15:0] option_number;
      logic [1:0]  value_format;
      logic [7:0]  value_byte;
      logic [16:0] option_length;
      logic [63:0] uint_value;
      logic [1:0]  error_code;
   } result_type;

   // option class by absolute number, unknown numbers are opaque
   function automatic logic [1:0] classify(input logic [15:0] num);
      logic [1:0] fmt;
      if (num == 16'd5) begin
         fmt = FMT_EMPTY;
      end else if (num inside {16'd6, 16'd7, 16'd12, 16'd14, 16'd17, 16'd23,
                               16'd27, 16'd28, 16'd60, 16'd258}) begin
         fmt = FMT_UINT;
      end else if (num inside {16'd3, 16'd8, 16'd11, 16'd15, 16'd20, 16'd35,
                               16'd39}) begin
         fmt = FMT_STRING;
      end else begin
         fmt = FMT_OPAQUE;
      end
      return fmt;
   endfunction

endpackage

// ===== design/coapd_core.sv =====
// ----------------------------------------------------------------------------
// coapd_core
// option parse state and the single pass decode of one option byte
// ----------------------------------------------------------------------------
module coapd_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             in_byte,
   input  logic                   restart,
   output logic                   emit,
   output coapd_pkg::result_type  result
);

   coapd_pkg::phase_type phase_ff, phase_in;
   logic [15:0] number_ff, number_in;
   logic [3:0]  nibble_ff, nibble_in;
   logic [16:0] ext_ff, ext_in;
   logic [16:0] remain_ff, remain_in;
   logic [1:0]  format_ff, format_in;
   logic [63:0] uacc_ff, uacc_in;

   coapd_pkg::phase_type eff_phase;
   logic [15:0] eff_number;
   logic [3:0]  delta_nib;
   logic [3:0]  len_nib;
   logic        do_delta;
   logic        do_len;
   logic [16:0] delta;
   logic [16:0] len;
   logic [17:0] sum;
   logic [16:0] remain_dec;
   logic [63:0] uacc_shift;

   always_comb begin
      eff_phase  = restart ? coapd_pkg::PH_HEADER : phase_ff;
      eff_number = restart ? 16'd0 : number_ff;
      delta_nib  = in_byte[7:4];
      len_nib    = (eff_phase == coapd_pkg::PH_HEADER) ? in_byte[3:0] : nibble_ff;

      phase_in  = eff_phase;
      number_in = eff_number;
      nibble_in = nibble_ff;
      ext_in    = ext_ff;
      remain_in = remain_ff;
      format_in = format_ff;
      uacc_in   = uacc_ff;

      do_delta   = 1'b0;
      do_len     = 1'b0;
      delta      = 17'd0;
      len        = 17'd0;
      sum        = 18'd0;
      remain_dec = remain_ff - 17'd1;
      uacc_shift = {uacc_ff[55:0], in_byte};

      emit   = 1'b0;
      result = '0;

      case (eff_phase)
         coapd_pkg::PH_HEADER: begin
            nibble_in = in_byte[3:0];
            if (delta_nib == coapd_pkg::NIB_RESERVED) begin
               emit              = 1'b1;
               result.event_res  = coapd_pkg::EV_ERROR;
               result.error_code = coapd_pkg::ERR_DELTA15;
               phase_in          = coapd_pkg::PH_ERROR;
            end else if (delta_nib <= coapd_pkg::NIB_MAX_SHORT) begin
               do_delta = 1'b1;
               delta    = {13'd0, delta_nib};
            end else if (delta_nib == coapd_pkg::NIB_EXT_ONE) begin
               ext_in   = coapd_pkg::EXT_ONE;
               phase_in = coapd_pkg::PH_DELTA_LO;
            end else begin
               phase_in = coapd_pkg::PH_DELTA_HI;
            end
         end
         coapd_pkg::PH_DELTA_HI: begin
            ext_in   = coapd_pkg::EXT_TWO + {1'b0, in_byte, 8'h00};
            phase_in = coapd_pkg::PH_DELTA_LO;
         end
         coapd_pkg::PH_DELTA_LO: begin
            do_delta = 1'b1;
            delta    = ext_ff + {9'd0, in_byte};
         end
         coapd_pkg::PH_LEN_HI: begin
            ext_in   = coapd_pkg::EXT_TWO + {1'b0, in_byte, 8'h00};
            phase_in = coapd_pkg::PH_LEN_LO;
         end
         coapd_pkg::PH_LEN_LO: begin
            do_len = 1'b1;
            len    = ext_ff + {9'd0, in_byte};
         end
         coapd_pkg::PH_VALUE: begin
            remain_in = remain_dec;
            if (format_ff == coapd_pkg::FMT_UINT) begin
               uacc_in = uacc_shift;
            end
            if (remain_dec == 17'd0) begin
               emit                 = 1'b1;
               phase_in             = coapd_pkg::PH_HEADER;
               result.event_res     = coapd_pkg::EV_COMPLETE;
               result.value_format  = format_ff;
               result.option_length = ext_ff;
               if (format_ff == coapd_pkg::FMT_UINT) begin
                  result.uint_value = uacc_shift;
               end else if (format_ff != coapd_pkg::FMT_EMPTY) begin
                  result.value_byte = in_byte;
               end
            end else if (format_ff == coapd_pkg::FMT_OPAQUE ||
                         format_ff == coapd_pkg::FMT_STRING) begin
               emit                 = 1'b1;
               result.event_res     = coapd_pkg::EV_VALUE;
               result.value_format  = format_ff;
               result.value_byte    = in_byte;
               result.option_length = ext_ff;
            end
         end
         default: begin
            // error hold: swallow bytes until restart
         end
      endcase

      if (do_delta) begin
         sum = {2'b00, eff_number} + {1'b0, delta};
         if (sum[17:16] != 2'b00) begin
            emit              = 1'b1;
            result.event_res  = coapd_pkg::EV_ERROR;
            result.error_code = coapd_pkg::ERR_OVERFLOW;
            phase_in          = coapd_pkg::PH_ERROR;
         end else begin
            number_in = sum[15:0];
            format_in = coapd_pkg::classify(sum[15:0]);
            if (len_nib == coapd_pkg::NIB_RESERVED) begin
               emit              = 1'b1;
               result.event_res  = coapd_pkg::EV_ERROR;
               result.error_code = coapd_pkg::ERR_LENGTH15;
               phase_in          = coapd_pkg::PH_ERROR;
            end else if (len_nib <= coapd_pkg::NIB_MAX_SHORT) begin
               do_len = 1'b1;
               len    = {13'd0, len_nib};
            end else if (len_nib == coapd_pkg::NIB_EXT_ONE) begin
               ext_in   = coapd_pkg::EXT_ONE;
               phase_in = coapd_pkg::PH_LEN_LO;
            end else begin
               phase_in = coapd_pkg::PH_LEN_HI;
            end
         end
      end

      if (do_len) begin
         ext_in    = len;
         remain_in = len;
         uacc_in   = 64'd0;
         if (len == 17'd0) begin
            emit                = 1'b1;
            phase_in            = coapd_pkg::PH_HEADER;
            result.event_res    = coapd_pkg::EV_COMPLETE;
            result.value_format = format_in;
         end else begin
            phase_in = coapd_pkg::PH_VALUE;
         end
      end

      // option number reported is the running number after this byte
      result.option_number = number_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= coapd_pkg::PH_HEADER;
         number_ff <= 16'd0;
         nibble_ff <= 4'd0;
         ext_ff    <= 17'd0;
         remain_ff <= 17'd0;
         format_ff <= coapd_pkg::FMT_EMPTY;
         uacc_ff   <= 64'd0;
      end else if (step) begin
         phase_ff  <= phase_in;
         number_ff <= number_in;
         nibble_ff <= nibble_in;
         ext_ff    <= ext_in;
         remain_ff <= remain_in;
         format_ff <= format_in;
         uacc_ff   <= uacc_in;
      end
   end

endmodule

// ===== design/coap_option_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// coap_option_stream_decoder_top
// streaming decoder for the option area of a coap message
// ----------------------------------------------------------------------------
// The block takes the option area one byte per beat and sustains one byte per
// clock cycle while rsp_tready does not stall it; a byte's result beat goes from
// the input register through one decode pass into the result register.
// The rate is set by the single-pass decode between those two registers: the
// header nibbles, extended delta and length bytes, running option number and
// value byte tracking all update in a single pass per byte. Each byte gives zero
// or one result beat: value bytes of opaque and string options, an option
// complete beat (with the uint value for integer options), or a single error
// beat after which bytes are swallowed until a beat with restart set. There is
// no clearing pass after reset; the block is ready in the first cycle.
module coap_option_stream_decoder_top (
   input  logic          clock,
   input  logic          reset,

   // input stream
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,    // [7:0] in_byte
   input  logic          req_tuser,    // [0] restart

   // result stream
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [111:0]  rsp_tdata,    // [15:0] option_number, [17:16] value_format,
                                       // [25:18] value_byte, [42:26] option_length,
                                       // [106:43] uint_value, [108:107] error_code,
                                       // [111:109] zero
   output logic [1:0]    rsp_tuser     // [1:0] event_res
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_restart_ff;

   // result register
   logic                  out_valid_ff, out_valid_in;
   coapd_pkg::result_type out_ff;

   logic                  advance;
   logic                  emit;
   coapd_pkg::result_type result;

   // decode the held byte when the result register can take its beat
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = (out_valid_ff && !rsp_tready) || (advance && emit);

   coapd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_byte (in_byte_ff),
      .restart (in_restart_ff),
      .emit    (emit),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff    <= req_tdata;
         in_restart_ff <= req_tuser;
      end
      if (advance && emit) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.event_res;
   assign rsp_tdata  = {3'b000,
                        out_ff.error_code,
                        out_ff.uint_value,
                        out_ff.option_length,
                        out_ff.value_byte,
                        out_ff.value_format,
                        out_ff.option_number};

`ifndef ASSERT_OFF
   // an error beat always carries a nonzero error code
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == coapd_pkg::EV_ERROR) |-> (rsp_tdata[108:107] != 2'b00))
      else $error("error beat without error code");

   // value byte beats only come from opaque or string options
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == coapd_pkg::EV_VALUE) |->
      (rsp_tdata[17:16] == coapd_pkg::FMT_OPAQUE || rsp_tdata[17:16] == coapd_pkg::FMT_STRING))
      else $error("value beat with wrong format");

   // a held byte with a stalled result beat blocks new input
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken while pipeline stalled");

   // a stalled result beat stays valid
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> out_valid_ff)
      else $error("result beat dropped under stall");
`endif

endmodule
